FILE: hdl/pidcdm_pkg.sv
package pidcdm_pkg;

  // Field and datapath widths.
  localparam int MeasW   = 16;
  localparam int GainW   = 24;
  localparam int ErrW    = MeasW + 1;
  localparam int SumW    = 32;
  localparam int LimW    = 31;
  localparam int DriveW  = 32;
  localparam int CfgW    = 31;
  localparam int CfgIdxW = 3;
  localparam int MulBW   = SumW + 1;
  localparam int ProdW   = GainW + MulBW;
  localparam int AccW    = ProdW + 3;
  localparam int PcW     = 5;
  localparam int QuoW    = LimW;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CfgMode       = 3'd0,
    CfgGainP      = 3'd1,
    CfgGainI      = 3'd2,
    CfgGainD      = 3'd3,
    CfgSetpoint   = 3'd4,
    CfgDriveLimit = 3'd5
  } cfg_idx_e;

  // Input opcodes.
  typedef enum logic {
    OpCompute = 1'b0,
    OpClear   = 1'b1
  } opcode_e;

  // Microcode fields.
  typedef enum logic [1:0] {
    MaKp,
    MaKi,
    MaKd
  } mul_a_e;

  typedef enum logic [2:0] {
    MbErr,
    MbDiff1,
    MbDiff2,
    MbSum,
    MbOld
  } mul_b_e;

  typedef enum logic [2:0] {
    AccHold,
    AccClear,
    AccAdd,
    AccLoadDrv,
    AccLoadPd
  } acc_op_e;

  typedef enum logic [2:0] {
    ActNone,
    ActLoadErr,
    ActDivStart,
    ActSavePd,
    ActSumUpdate,
    ActUndo,
    ActFinish,
    ActClear
  } act_e;

  typedef enum logic [2:0] {
    JmpNext,
    JmpAlways,
    JmpIfClear,
    JmpIfInc,
    JmpIfDivBusy,
    JmpIfNoUndo
  } jmp_e;

  typedef struct packed {
    mul_a_e          mul_a;
    mul_b_e          mul_b;
    acc_op_e         acc_op;
    act_e            act;
    jmp_e            jmp;
    logic [PcW-1:0]  target;
  } uword_t;

  // Program entry points.
  localparam logic [PcW-1:0] StDecode = 5'd0;
  localparam logic [PcW-1:0] StPos    = 5'd2;
  localparam logic [PcW-1:0] StWait   = 5'd5;
  localparam logic [PcW-1:0] StFin    = 5'd12;
  localparam logic [PcW-1:0] StInc    = 5'd13;
  localparam logic [PcW-1:0] StClear  = 5'd17;

  // Control store. A product issued in one step is added by the next step.
  function automatic uword_t ucode_rom(input logic [PcW-1:0] pc);
    uword_t w;
    w = '{MaKp, MbErr, AccHold, ActNone, JmpAlways, StFin};
    case (pc)
      5'd0:  w = '{MaKp, MbErr,   AccHold,    ActLoadErr,   JmpIfClear,   StClear};
      5'd1:  w = '{MaKp, MbErr,   AccHold,    ActNone,      JmpIfInc,     StInc};
      5'd2:  w = '{MaKp, MbErr,   AccClear,   ActDivStart,  JmpNext,      StFin};
      5'd3:  w = '{MaKd, MbDiff1, AccAdd,     ActNone,      JmpNext,      StFin};
      5'd4:  w = '{MaKp, MbErr,   AccAdd,     ActNone,      JmpNext,      StFin};
      5'd5:  w = '{MaKp, MbErr,   AccHold,    ActSavePd,    JmpIfDivBusy, StWait};
      5'd6:  w = '{MaKp, MbErr,   AccHold,    ActSumUpdate, JmpNext,      StFin};
      5'd7:  w = '{MaKi, MbSum,   AccHold,    ActNone,      JmpNext,      StFin};
      5'd8:  w = '{MaKp, MbErr,   AccAdd,     ActNone,      JmpNext,      StFin};
      5'd9:  w = '{MaKp, MbErr,   AccHold,    ActNone,      JmpIfNoUndo,  StFin};
      5'd10: w = '{MaKi, MbOld,   AccLoadPd,  ActUndo,      JmpNext,      StFin};
      5'd11: w = '{MaKp, MbErr,   AccAdd,     ActNone,      JmpAlways,    StFin};
      5'd12: w = '{MaKp, MbErr,   AccHold,    ActFinish,    JmpNext,      StFin};
      5'd13: w = '{MaKp, MbDiff1, AccLoadDrv, ActNone,      JmpNext,      StFin};
      5'd14: w = '{MaKi, MbErr,   AccAdd,     ActNone,      JmpNext,      StFin};
      5'd15: w = '{MaKd, MbDiff2, AccAdd,     ActNone,      JmpNext,      StFin};
      5'd16: w = '{MaKp, MbErr,   AccAdd,     ActNone,      JmpAlways,    StFin};
      5'd17: w = '{MaKp, MbErr,   AccHold,    ActClear,     JmpNext,      StFin};
      default: w = '{MaKp, MbErr, AccHold, ActNone, JmpAlways, StFin};
    endcase
    return w;
  endfunction

endpackage

FILE: hdl/pid_controller_dual_mode.sv
// Dual-mode fixed-point PID controller. Each input transaction carries a
// signed 16-bit measurement and produces exactly one output transaction with
// a signed Q16.16 drive clamped to +/- drive_limit and a flag that is set when
// the clamp was hit. Mode 0 runs a positional PID with a bounded integral
// (bound = drive_limit / |gain_i|) and conditional integration; mode 1 runs an
// incremental PID that accumulates onto the last drive. Opcode 1 clears all
// history and returns a zero drive. Gains are signed Q8.16. A small microcode
// program steps one shared 24 x 33 bit multiplier and one accumulator; the
// positional bound comes from a one-bit-per-cycle divider. The last step of
// the program waits for as long as the previous result is still stalled in
// the output register. One transaction is processed at a time, but a new one
// is accepted while the previous result is still waiting in the output
// register. Configuration is written through a plain write port and must
// only change while the block is idle.
module pid_controller_dual_mode import pidcdm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Input channel.
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 opcode_i,
  input  logic signed [MeasW-1:0] measurement_i,
  // Output channel.
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic signed [DriveW-1:0] drive_o,
  output logic                 clamped_o,
  // Configuration write port.
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [CfgW-1:0]      cfg_wdata_i
);

  // Configuration registers.
  logic                    mode_q;
  logic signed [GainW-1:0] gain_p_q, gain_i_q, gain_d_q;
  logic signed [MeasW-1:0] setpoint_q;
  logic [LimW-1:0]         limit_q;

  // Controller history.
  logic signed [SumW-1:0]   error_sum_q;
  logic signed [ErrW-1:0]   prev_err_q, sprev_err_q;
  logic signed [DriveW-1:0] drive_acc_q;

  // Sequencer and datapath.
  logic                    busy_q;
  logic [PcW-1:0]          pc_q, pc_d;
  logic                    op_q;
  logic signed [MeasW-1:0] meas_q;
  logic signed [ErrW-1:0]  err_q;
  logic signed [ProdW-1:0] prod_q, prod_d;
  logic signed [AccW-1:0]  acc_q, acc_d, pd_q;
  logic signed [SumW-1:0]  old_sum_q, sum_d;
  logic                    out_valid_q, clamped_q;
  logic signed [DriveW-1:0] drive_q, drive_d;
  logic                    hit_d;

  uword_t                  uw;
  logic                    in_accept, out_free, hold, exec, jump;
  logic signed [GainW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic signed [ErrW:0]    diff1;
  logic signed [ErrW+2:0]  diff2;
  logic [GainW-1:0]        ki_abs;
  logic                    div_busy;
  logic [QuoW-1:0]         bound;
  logic signed [SumW:0]    sum_trial, bnd_pos, bnd_neg;
  logic signed [AccW-1:0]  lim_pos, lim_neg;
  logic                    err_pos, err_neg, undo;

  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_stall_o = busy_q;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign uw = ucode_rom(pc_q);

  // The result step waits while the output register still holds an untaken result.
  assign hold = (uw.act == ActFinish || uw.act == ActClear) && !out_free;
  assign exec = busy_q && !hold;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= 1'b0;
      gain_p_q   <= '0;
      gain_i_q   <= '0;
      gain_d_q   <= '0;
      setpoint_q <= '0;
      limit_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgMode:       mode_q     <= cfg_wdata_i[0];
        CfgGainP:      gain_p_q   <= cfg_wdata_i[GainW-1:0];
        CfgGainI:      gain_i_q   <= cfg_wdata_i[GainW-1:0];
        CfgGainD:      gain_d_q   <= cfg_wdata_i[GainW-1:0];
        CfgSetpoint:   setpoint_q <= cfg_wdata_i[MeasW-1:0];
        CfgDriveLimit: limit_q    <= cfg_wdata_i[LimW-1:0];
        default: ;
      endcase
    end
  end

  // Error differences for the derivative and incremental terms.
  assign diff1 = {err_q[ErrW-1], err_q} - {prev_err_q[ErrW-1], prev_err_q};
  assign diff2 = {{3{err_q[ErrW-1]}}, err_q}
               - {{2{prev_err_q[ErrW-1]}}, prev_err_q, 1'b0}
               + {{3{sprev_err_q[ErrW-1]}}, sprev_err_q};

  // Shared multiplier operands; the product is registered every cycle.
  always_comb begin
    case (uw.mul_a)
      MaKp:    mul_a = gain_p_q;
      MaKi:    mul_a = gain_i_q;
      MaKd:    mul_a = gain_d_q;
      default: mul_a = gain_p_q;
    endcase
    case (uw.mul_b)
      MbErr:   mul_b = {{(MulBW-ErrW){err_q[ErrW-1]}}, err_q};
      MbDiff1: mul_b = {{(MulBW-ErrW-1){diff1[ErrW]}}, diff1};
      MbDiff2: mul_b = {{(MulBW-ErrW-3){diff2[ErrW+2]}}, diff2};
      MbSum:   mul_b = {error_sum_q[SumW-1], error_sum_q};
      MbOld:   mul_b = {old_sum_q[SumW-1], old_sum_q};
      default: mul_b = '0;
    endcase
    prod_d = ProdW'(mul_a) * ProdW'(mul_b);
  end

  always_comb begin
    case (uw.acc_op)
      AccClear:   acc_d = '0;
      AccAdd:     acc_d = acc_q + {{(AccW-ProdW){prod_q[ProdW-1]}}, prod_q};
      AccLoadDrv: acc_d = {{(AccW-DriveW){drive_acc_q[DriveW-1]}}, drive_acc_q};
      AccLoadPd:  acc_d = pd_q;
      default:    acc_d = acc_q;
    endcase
  end

  // Integral bound: drive_limit / |gain_i|, truncated.
  assign ki_abs = gain_i_q[GainW-1] ? GainW'(~gain_i_q + 1'b1) : gain_i_q;

  pidcdm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (exec && uw.act == ActDivStart),
    .dividend_i (limit_q),
    .divisor_i  (ki_abs),
    .busy_o     (div_busy),
    .quotient_o (bound)
  );

  // Saturating integral update; zero gain or zero limit empties the integral.
  always_comb begin
    sum_trial = {error_sum_q[SumW-1], error_sum_q}
              + {{(SumW+1-ErrW){err_q[ErrW-1]}}, err_q};
    bnd_pos   = {2'b00, bound};
    bnd_neg   = -bnd_pos;
    if (gain_i_q == '0 || limit_q == '0) begin
      sum_d = '0;
    end else if (sum_trial > bnd_pos) begin
      sum_d = bnd_pos[SumW-1:0];
    end else if (sum_trial < bnd_neg) begin
      sum_d = bnd_neg[SumW-1:0];
    end else begin
      sum_d = sum_trial[SumW-1:0];
    end
  end

  // Conditional integration: back out the integral step when the drive would
  // run past the limit in the direction of the error.
  assign lim_pos = {{(AccW-LimW){1'b0}}, limit_q};
  assign lim_neg = -lim_pos;
  assign err_pos = !err_q[ErrW-1] && (err_q != '0);
  assign err_neg = err_q[ErrW-1];
  assign undo    = (limit_q != '0)
                && ((acc_q > lim_pos && err_pos) || (acc_q < lim_neg && err_neg));

  // Output clamp.
  always_comb begin
    if (acc_q > lim_pos) begin
      drive_d = lim_pos[DriveW-1:0];
      hit_d   = 1'b1;
    end else if (acc_q < lim_neg) begin
      drive_d = lim_neg[DriveW-1:0];
      hit_d   = 1'b1;
    end else begin
      drive_d = acc_q[DriveW-1:0];
      hit_d   = 1'b0;
    end
  end

  // Step counter with conditional jumps.
  always_comb begin
    case (uw.jmp)
      JmpNext:      jump = 1'b0;
      JmpAlways:    jump = 1'b1;
      JmpIfClear:   jump = (op_q == OpClear);
      JmpIfInc:     jump = mode_q;
      JmpIfDivBusy: jump = div_busy;
      JmpIfNoUndo:  jump = !undo;
      default:      jump = 1'b0;
    endcase
    if (!exec) begin
      pc_d = pc_q;
    end else if (jump) begin
      pc_d = uw.target;
    end else begin
      pc_d = pc_q + 1'b1;
    end
  end

  // Control state and controller history.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pc_q        <= StDecode;
      out_valid_q <= 1'b0;
      error_sum_q <= '0;
      prev_err_q  <= '0;
      sprev_err_q <= '0;
      drive_acc_q <= '0;
    end else begin
      if (in_accept) begin
        busy_q <= 1'b1;
        pc_q   <= StDecode;
      end else begin
        pc_q <= pc_d;
      end

      if (exec && (uw.act == ActFinish || uw.act == ActClear)) begin
        busy_q      <= 1'b0;
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      if (exec) begin
        case (uw.act)
          ActSumUpdate: error_sum_q <= sum_d;
          ActUndo:      error_sum_q <= old_sum_q;
          ActFinish: begin
            drive_acc_q <= drive_d;
            prev_err_q  <= err_q;
            if (mode_q) begin
              sprev_err_q <= prev_err_q;
            end
          end
          ActClear: begin
            error_sum_q <= '0;
            prev_err_q  <= '0;
            sprev_err_q <= '0;
            drive_acc_q <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q   <= opcode_i;
      meas_q <= measurement_i;
    end
    prod_q <= prod_d;
    if (exec) begin
      acc_q <= acc_d;
      case (uw.act)
        ActLoadErr:   err_q <= {setpoint_q[MeasW-1], setpoint_q}
                             - {meas_q[MeasW-1], meas_q};
        ActSavePd:    pd_q <= acc_q;
        ActSumUpdate: old_sum_q <= error_sum_q;
        ActFinish: begin
          drive_q   <= drive_d;
          clamped_q <= hit_d;
        end
        ActClear: begin
          drive_q   <= '0;
          clamped_q <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign drive_o     = drive_q;
  assign clamped_o   = clamped_q;

endmodule

FILE: hdl/pidcdm_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module pidcdm_div import pidcdm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [QuoW-1:0]  dividend_i,
  input  logic [GainW-1:0] divisor_i,
  output logic             busy_o,
  output logic [QuoW-1:0]  quotient_o
);

  localparam int CntW = $clog2(QuoW + 1);

  logic [CntW-1:0]  cnt_q;
  logic [GainW-1:0] rem_q, rem_d;
  logic [QuoW-1:0]  quo_q, quo_d;
  logic [GainW:0]   shifted;
  logic             fits;

  always_comb begin
    shifted = {rem_q, quo_q[QuoW-1]};
    fits    = (shifted >= {1'b0, divisor_i});
    rem_d   = fits ? GainW'(shifted - {1'b0, divisor_i}) : shifted[GainW-1:0];
    quo_d   = {quo_q[QuoW-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CntW'(QuoW);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
    end else if (cnt_q != '0) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign busy_o     = (cnt_q != '0);
  assign quotient_o = quo_q;

endmodule

FILE: hdl/pidcdm_chk.sv
// Port-level checks for the PID controller.
module pidcdm_chk import pidcdm_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_stall_o,
  input logic                     out_valid_o,
  input logic                     out_stall_i,
  input logic signed [DriveW-1:0] drive_o,
  input logic                     clamped_o,
  input logic                     cfg_we_i,
  input logic [CfgIdxW-1:0]       cfg_index_i,
  input logic [CfgW-1:0]          cfg_wdata_i
);

  logic [1:0]        pend_q, pend_d;
  logic [LimW-1:0]   lim_q;
  logic [DriveW-1:0] lim_pos, lim_neg;
  logic              in_acc, out_acc;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;
  assign pend_d  = pend_q + {1'b0, in_acc} - {1'b0, out_acc};
  assign lim_pos = {1'b0, lim_q};
  assign lim_neg = ~lim_pos + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      lim_q  <= '0;
    end else begin
      pend_q <= pend_d;
      if (cfg_we_i && cfg_index_i == CfgDriveLimit) begin
        lim_q <= cfg_wdata_i[LimW-1:0];
      end
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(drive_o) && $stable(clamped_o))
    else $error("result changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("input not stalled while a transaction is in progress");

  a_no_spurious_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != 2'd0)
    else $error("result without a pending transaction");

  a_at_most_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != 2'd3)
    else $error("more than two transactions in flight");

  a_clamp_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && clamped_o |-> drive_o == lim_pos || drive_o == lim_neg)
    else $error("clamped drive is not at the limit");

endmodule

bind pid_controller_dual_mode pidcdm_chk u_pidcdm_chk (.*);
